>>> hdl/qualified_identifier_validator_top_assert.svh
// Assertion macros for the qualified identifier validator.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef QUALIFIED_IDENTIFIER_VALIDATOR_TOP_ASSERT_SVH
`define QUALIFIED_IDENTIFIER_VALIDATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define QIV_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define QIV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define QIV_ASSERT_NOW(label, ante, cons, msg)
`define QIV_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> hdl/qiv_pkg.sv
package qiv_pkg;

   localparam int MAX_TOTAL_LENGTH     = 2048;
   localparam int MAX_COMPONENT_LENGTH = 255;
   localparam int MAX_COMPONENTS       = 8;

   localparam int TOTAL_W    = $clog2(MAX_TOTAL_LENGTH + 2);
   localparam int COMP_LEN_W = $clog2(MAX_COMPONENT_LENGTH + 2);
   localparam int IDX_W      = $clog2(MAX_COMPONENTS + 1);
   localparam int KW_POS_W   = 5;
   localparam int KW_MAX_CHARS = 21;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Character codes.
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CH_LOWER_A  = 8'h61;
   localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_DOT      = 8'h2E;
   localparam logic [7:0] CH_SLASH    = 8'h2F;
   localparam logic [7:0] CH_V        = 8'h76;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // Requested kinds.
   localparam logic [3:0] KIND_FEATURE      = 4'd1;
   localparam logic [3:0] KIND_COMMAND      = 4'd2;
   localparam logic [3:0] KIND_CMD_PARAM    = 4'd3;
   localparam logic [3:0] KIND_CMD_RESP     = 4'd4;
   localparam logic [3:0] KIND_INTERMEDIATE = 4'd5;
   localparam logic [3:0] KIND_ERROR        = 4'd6;
   localparam logic [3:0] KIND_PROPERTY     = 4'd7;
   localparam logic [3:0] KIND_DATATYPE     = 4'd8;
   localparam logic [3:0] KIND_METADATA     = 4'd9;

   // Suffix keywords; the identifier code stands for a free identifier component.
   localparam logic [3:0] KW_IDENT        = 4'd0;
   localparam logic [3:0] KW_COMMAND      = 4'd1;
   localparam logic [3:0] KW_PARAMETER    = 4'd2;
   localparam logic [3:0] KW_RESPONSE     = 4'd3;
   localparam logic [3:0] KW_INTERMEDIATE = 4'd4;
   localparam logic [3:0] KW_DEFINED      = 4'd5;
   localparam logic [3:0] KW_PROPERTY     = 4'd6;
   localparam logic [3:0] KW_DATATYPE     = 4'd7;
   localparam logic [3:0] KW_METADATA     = 4'd8;

   typedef enum logic [2:0] {
      ROLE_DOTTED,
      ROLE_IDENT,
      ROLE_VERSION,
      ROLE_KEYWORD,
      ROLE_NONE
   } qiv_role_type;

   typedef struct packed {
      qiv_role_type role;
      logic [3:0]   kw;
   } qiv_role_info_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_lower;
      logic       is_digit;
      logic       is_dot;
      logic       is_slash;
      logic       is_v;
      logic [3:0] kind;
      logic       last;
   } qiv_item_type;

   typedef struct packed {
      logic nonempty;
      logic full;
   } qiv_fifo_status_type;

   // Number of components that follow the version component.
   function automatic logic [2:0] suffix_len(input logic [3:0] kind);
      logic [2:0] len;
      case (kind)
         KIND_COMMAND, KIND_ERROR, KIND_PROPERTY, KIND_DATATYPE, KIND_METADATA: len = 3'd2;
         KIND_CMD_PARAM, KIND_CMD_RESP, KIND_INTERMEDIATE: len = 3'd4;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [3:0] suffix_kw(input logic [3:0] kind, input logic [1:0] slot);
      logic [3:0] kw;
      kw = KW_IDENT;
      if (slot == 2'd0) begin
         case (kind)
            KIND_COMMAND, KIND_CMD_PARAM, KIND_CMD_RESP, KIND_INTERMEDIATE: kw = KW_COMMAND;
            KIND_ERROR:    kw = KW_DEFINED;
            KIND_PROPERTY: kw = KW_PROPERTY;
            KIND_DATATYPE: kw = KW_DATATYPE;
            KIND_METADATA: kw = KW_METADATA;
            default:       kw = KW_IDENT;
         endcase
      end else if (slot == 2'd2) begin
         case (kind)
            KIND_CMD_PARAM:    kw = KW_PARAMETER;
            KIND_CMD_RESP:     kw = KW_RESPONSE;
            KIND_INTERMEDIATE: kw = KW_INTERMEDIATE;
            default:           kw = KW_IDENT;
         endcase
      end
      return kw;
   endfunction

   function automatic logic [KW_POS_W-1:0] kw_len(input logic [3:0] kw);
      logic [KW_POS_W-1:0] len;
      case (kw)
         KW_COMMAND:      len = KW_POS_W'(7);
         KW_PARAMETER:    len = KW_POS_W'(9);
         KW_RESPONSE:     len = KW_POS_W'(8);
         KW_INTERMEDIATE: len = KW_POS_W'(20);
         KW_DEFINED:      len = KW_POS_W'(21);
         KW_PROPERTY:     len = KW_POS_W'(8);
         KW_DATATYPE:     len = KW_POS_W'(8);
         KW_METADATA:     len = KW_POS_W'(8);
         default:         len = '0;
      endcase
      return len;
   endfunction

   // Character at a position of a keyword; the text sits right-aligned in the vector.
   function automatic logic [7:0] kw_char(input logic [3:0] kw,
                                          input logic [KW_POS_W-1:0] pos);
      logic [8*KW_MAX_CHARS-1:0] txt;
      logic [KW_POS_W-1:0]       len;
      logic [7:0]                ch;
      len = kw_len(kw);
      ch  = '0;
      case (kw)
         KW_COMMAND:      txt = (8*KW_MAX_CHARS)'("command");
         KW_PARAMETER:    txt = (8*KW_MAX_CHARS)'("parameter");
         KW_RESPONSE:     txt = (8*KW_MAX_CHARS)'("response");
         KW_INTERMEDIATE: txt = (8*KW_MAX_CHARS)'("intermediateresponse");
         KW_DEFINED:      txt = (8*KW_MAX_CHARS)'("definedexecutionerror");
         KW_PROPERTY:     txt = (8*KW_MAX_CHARS)'("property");
         KW_DATATYPE:     txt = (8*KW_MAX_CHARS)'("datatype");
         KW_METADATA:     txt = (8*KW_MAX_CHARS)'("metadata");
         default:         txt = '0;
      endcase
      if (pos < len) begin
         ch = txt[8*(len - pos - KW_POS_W'(1)) +: 8];
      end
      return ch;
   endfunction

   function automatic qiv_role_info_type role_of(input logic [IDX_W-1:0] idx,
                                                 input logic [3:0] kind);
      qiv_role_info_type info;
      logic [IDX_W-1:0]  slot;
      info.role = ROLE_NONE;
      info.kw   = KW_IDENT;
      slot      = idx - IDX_W'(4);
      if (idx <= IDX_W'(1)) begin
         info.role = ROLE_DOTTED;
      end else if (idx == IDX_W'(2)) begin
         info.role = ROLE_IDENT;
      end else if (idx == IDX_W'(3)) begin
         info.role = ROLE_VERSION;
      end else if (slot < IDX_W'(suffix_len(kind))) begin
         info.kw   = suffix_kw(kind, slot[1:0]);
         info.role = (info.kw == KW_IDENT) ? ROLE_IDENT : ROLE_KEYWORD;
      end
      return info;
   endfunction

   // Whether the component being closed is well formed.
   function automatic logic close_ok(input qiv_role_info_type info,
                                     input logic [COMP_LEN_W-1:0] len,
                                     input logic piece_start,
                                     input logic [KW_POS_W-1:0] kw_pos);
      logic ok;
      case (info.role)
         ROLE_DOTTED:  ok = (len != '0) && !piece_start;
         ROLE_IDENT:   ok = (len != '0);
         ROLE_VERSION: ok = (len >= COMP_LEN_W'(2));
         ROLE_KEYWORD: ok = (kw_pos == kw_len(info.kw));
         default:      ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

>>> hdl/qiv_front.sv
module qiv_front (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_char_code,
   input  logic [3:0]            req_fqi_kind,
   input  logic                  req_last,
   input  qiv_pkg::qiv_fifo_status_type fifo_status,
   output logic                  push,
   output qiv_pkg::qiv_item_type item
);
   import qiv_pkg::*;

   logic [7:0] folded;

   // Fold upper case letters to lower case before any class test.
   assign folded = (req_char_code >= CH_UPPER_A && req_char_code <= CH_UPPER_Z) ?
                   req_char_code + CASE_OFFSET : req_char_code;

   assign req_ready = !fifo_status.full;
   assign push      = req_valid && req_ready;

   always_comb begin
      item.char_code = folded;
      item.is_lower  = (folded >= CH_LOWER_A) && (folded <= CH_LOWER_Z);
      item.is_digit  = (folded >= CH_ZERO) && (folded <= CH_NINE);
      item.is_dot    = (folded == CH_DOT);
      item.is_slash  = (folded == CH_SLASH);
      item.is_v      = (folded == CH_V);
      item.kind      = req_fqi_kind;
      item.last      = req_last;
   end

endmodule

>>> hdl/qiv_fifo.sv
module qiv_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  qiv_pkg::qiv_item_type push_item,
   input  logic                  pop,
   output qiv_pkg::qiv_item_type pop_item,
   output qiv_pkg::qiv_fifo_status_type status
);
   import qiv_pkg::*;

   qiv_item_type            entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + FIFO_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item        = entry_ff[rd_ptr_ff];
   assign status.nonempty = (count_ff != '0);
   assign status.full     = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));

endmodule

>>> hdl/qiv_back.sv
module qiv_back (
   input  logic                  clock,
   input  logic                  reset,
   input  qiv_pkg::qiv_fifo_status_type fifo_status,
   input  qiv_pkg::qiv_item_type item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_valid_res
);
   import qiv_pkg::*;

   logic [TOTAL_W-1:0]    total_length_ff, total_length_in;
   logic [IDX_W-1:0]      component_index_ff, component_index_in;
   logic [COMP_LEN_W-1:0] component_length_ff, component_length_in;
   logic                  piece_start_ff, piece_start_in;
   logic [KW_POS_W-1:0]   keyword_position_ff, keyword_position_in;
   logic                  still_ok_ff, still_ok_in;
   logic                  expect_first_ff, expect_first_in;
   logic [3:0]            held_kind_ff, held_kind_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_valid_res_ff, rsp_valid_res_in;

   logic [3:0]            kind_now;
   logic [TOTAL_W-1:0]    total_next;
   logic [IDX_W-1:0]      idx_next;
   logic [COMP_LEN_W-1:0] len_next;
   logic                  ps_next;
   logic [KW_POS_W-1:0]   kwp_next;
   logic                  ok_next;
   logic                  final_ok;
   qiv_role_info_type     info_now;
   qiv_role_info_type     info_end;

   // A byte that closes a string may only leave when the result slot is free.
   assign pop = fifo_status.nonempty && (!item.last || !rsp_valid_ff || rsp_ready);

   assign kind_now = expect_first_ff ? item.kind : held_kind_ff;
   assign info_now = role_of(component_index_ff, kind_now);

   always_comb begin
      ok_next  = still_ok_ff;
      idx_next = component_index_ff;
      len_next = component_length_ff;
      ps_next  = piece_start_ff;
      kwp_next = keyword_position_ff;

      if (expect_first_ff && (item.kind < KIND_FEATURE || item.kind > KIND_METADATA)) begin
         ok_next = 1'b0;
      end

      total_next = (total_length_ff <= TOTAL_W'(MAX_TOTAL_LENGTH)) ?
                   total_length_ff + TOTAL_W'(1) : total_length_ff;
      if (total_next > TOTAL_W'(MAX_TOTAL_LENGTH)) begin
         ok_next = 1'b0;
      end

      if (item.is_slash) begin
         if (!close_ok(info_now, component_length_ff, piece_start_ff, keyword_position_ff)) begin
            ok_next = 1'b0;
         end
         if ({1'b0, component_index_ff} + (IDX_W + 1)'(1) >= (IDX_W + 1)'(MAX_COMPONENTS)) begin
            ok_next = 1'b0;
         end else begin
            idx_next = component_index_ff + IDX_W'(1);
         end
         len_next = '0;
         ps_next  = 1'b1;
         kwp_next = '0;
      end else begin
         case (info_now.role)
            ROLE_DOTTED: begin
               if (item.is_dot) begin
                  if (piece_start_ff) begin
                     ok_next = 1'b0;
                  end
                  ps_next = 1'b1;
               end else if (piece_start_ff) begin
                  if (!item.is_lower) begin
                     ok_next = 1'b0;
                  end
                  ps_next = 1'b0;
               end else if (!item.is_lower && !item.is_digit) begin
                  ok_next = 1'b0;
               end
            end
            ROLE_IDENT: begin
               if (component_length_ff == '0 ? !item.is_lower :
                   !(item.is_lower || item.is_digit)) begin
                  ok_next = 1'b0;
               end
            end
            ROLE_VERSION: begin
               if (component_length_ff == '0 ? !item.is_v : !item.is_digit) begin
                  ok_next = 1'b0;
               end
            end
            ROLE_KEYWORD: begin
               if (keyword_position_ff < kw_len(info_now.kw) &&
                   kw_char(info_now.kw, keyword_position_ff) == item.char_code) begin
                  kwp_next = keyword_position_ff + KW_POS_W'(1);
               end else begin
                  ok_next = 1'b0;
               end
            end
            default: begin
               ok_next = 1'b0;
            end
         endcase
         if (component_length_ff <= COMP_LEN_W'(MAX_COMPONENT_LENGTH)) begin
            len_next = component_length_ff + COMP_LEN_W'(1);
         end
         if ((info_now.role == ROLE_DOTTED || info_now.role == ROLE_IDENT) &&
             len_next > COMP_LEN_W'(MAX_COMPONENT_LENGTH)) begin
            ok_next = 1'b0;
         end
      end
   end

   // The end of the string closes the open component and checks the component count.
   assign info_end = role_of(idx_next, kind_now);
   assign final_ok = ok_next && close_ok(info_end, len_next, ps_next, kwp_next) &&
                     (idx_next == IDX_W'(3) + IDX_W'(suffix_len(kind_now)));

   always_comb begin
      total_length_in     = total_length_ff;
      component_index_in  = component_index_ff;
      component_length_in = component_length_ff;
      piece_start_in      = piece_start_ff;
      keyword_position_in = keyword_position_ff;
      still_ok_in         = still_ok_ff;
      expect_first_in     = expect_first_ff;
      held_kind_in        = held_kind_ff;
      if (pop) begin
         if (item.last) begin
            total_length_in     = '0;
            component_index_in  = '0;
            component_length_in = '0;
            piece_start_in      = 1'b1;
            keyword_position_in = '0;
            still_ok_in         = 1'b1;
            expect_first_in     = 1'b1;
            held_kind_in        = '0;
         end else begin
            total_length_in     = total_next;
            component_index_in  = idx_next;
            component_length_in = len_next;
            piece_start_in      = ps_next;
            keyword_position_in = kwp_next;
            still_ok_in         = ok_next;
            expect_first_in     = 1'b0;
            held_kind_in        = kind_now;
         end
      end
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_valid_res_in = rsp_valid_res_ff;
      if (pop && item.last) begin
         rsp_valid_in     = 1'b1;
         rsp_valid_res_in = final_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_length_ff     <= '0;
         component_index_ff  <= '0;
         component_length_ff <= '0;
         piece_start_ff      <= 1'b1;
         keyword_position_ff <= '0;
         still_ok_ff         <= 1'b1;
         expect_first_ff     <= 1'b1;
         held_kind_ff        <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         total_length_ff     <= total_length_in;
         component_index_ff  <= component_index_in;
         component_length_ff <= component_length_in;
         piece_start_ff      <= piece_start_in;
         keyword_position_ff <= keyword_position_in;
         still_ok_ff         <= still_ok_in;
         expect_first_ff     <= expect_first_in;
         held_kind_ff        <= held_kind_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_valid_res_ff <= rsp_valid_res_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_valid_res_ff;

endmodule

>>> hdl/qualified_identifier_validator_top.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_ready  | req_char_code[7:0], req_fqi_kind[3:0], req_last
// rsp     | out       | rsp_valid/rsp_ready  | rsp_valid_res
//
// One byte is taken per cycle while the queue is not full. Accepted bytes are written to
// the queue; the back end consumes each byte from the queue head and registers the result
// when it consumes the byte that ends a string. The result is held until rsp_ready takes it.
// Sustained rate is one request per cycle when nothing stalls, bounded by the update of the
// parser state in the back end.
// Reset is synchronous and active high; it empties the queue and restarts parsing.
// A held result stalls only bytes that end a string; the queue keeps req_ready high
// until it fills.
module qualified_identifier_validator_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic [3:0] req_fqi_kind,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_valid_res
);
   import qiv_pkg::*;

   `include "qualified_identifier_validator_top_assert.svh"

   // The front end folds case and tags each byte with its character class.
   // The back end walks the components of the string and builds the verdict.
   qiv_item_type        push_item;
   qiv_item_type        item;
   qiv_fifo_status_type fifo_status;
   logic                push;
   logic                pop;

   qiv_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_fqi_kind  (req_fqi_kind),
      .req_last      (req_last),
      .fifo_status   (fifo_status),
      .push          (push),
      .item          (push_item)
   );

   // The queue decouples classification from parsing so either side can stall alone.
   qiv_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (item),
      .status    (fifo_status)
   );

   qiv_back u_back (
      .clock         (clock),
      .reset         (reset),
      .fifo_status   (fifo_status),
      .item          (item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_valid_res (rsp_valid_res)
   );

   // A byte that ends a string must produce a result in the next cycle.
   `QIV_ASSERT_NEXT(a_result_after_last, pop && item.last, rsp_valid, "no result after last byte")
   // The queue never takes a request while full.
   `QIV_ASSERT_NOW(a_no_push_full, push, !fifo_status.full, "push into full queue")
   // The back end never reads an empty queue.
   `QIV_ASSERT_NOW(a_no_pop_empty, pop, fifo_status.nonempty, "pop from empty queue")
   // A pending result is never overwritten before it is taken.
   `QIV_ASSERT_NOW(a_no_overwrite, pop && item.last && rsp_valid, rsp_ready, "result overwritten")

endmodule
